@@ sv/dzbp_pkg.sv @@
// Shared types and constants of the delta/zigzag byte-plane encoder.
package dzbp_pkg;

    localparam int WORD_W      = 64;
    localparam int OFFSET_W    = 48;
    localparam int COUNT_W     = 25;
    localparam int ADDR_W      = 29;
    localparam int BYTE_W      = 8;
    localparam int NUM_WORDS   = 3;
    localparam int REC_BYTES   = NUM_WORDS * WORD_W / BYTE_W;
    localparam int BCNT_W      = $clog2(REC_BYTES);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BCNT_W-1:0] LAST_BYTE = BCNT_W'(REC_BYTES - 1);

    // One encoded record waiting to be serialized.
    typedef struct packed {
        logic [NUM_WORDS-1:0][WORD_W-1:0] words;
        logic [COUNT_W-1:0]               index;
        logic [COUNT_W-1:0]               stride;
        logic                             block_end;
    } rec_t;

endpackage

@@ sv/dzbp_front.sv @@
// Front end: takes records, delta/zigzag codes them and tracks block position.
module dzbp_front #(
    parameter int MAX_RECORDS = 16777216
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dzbp_pkg::COUNT_W-1:0]  cfg_data,
    input  logic                          push,
    input  logic                          q_full,
    input  logic [dzbp_pkg::WORD_W-1:0]   doc_id,
    input  logic [dzbp_pkg::WORD_W-1:0]   position_word,
    input  logic [dzbp_pkg::WORD_W-1:0]   payload_word,
    output logic                          q_write,
    output dzbp_pkg::rec_t                q_data
);
    import dzbp_pkg::*;

    localparam logic [31:0] MAX_W = 32'(MAX_RECORDS);

    logic [COUNT_W-1:0]  record_count_reg;
    logic [WORD_W-1:0]   prev_doc_reg,    prev_doc_next;
    logic [OFFSET_W-1:0] prev_off_reg,    prev_off_next;
    logic [COUNT_W-1:0]  index_reg,       index_next;

    logic [COUNT_W-1:0]  count_eff;
    logic                accept;
    logic [WORD_W-1:0]   doc_delta;
    logic [OFFSET_W-1:0] off_delta;
    logic [WORD_W-1:0]   word0;
    logic [WORD_W-1:0]   word1;
    logic [COUNT_W:0]    index_inc;
    logic                block_end;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            record_count_reg <= cfg_data;
        end
    end

    always_comb
    begin
        count_eff = ({7'b0, record_count_reg} > MAX_W) ? MAX_W[COUNT_W-1:0] : record_count_reg;
        accept    = push && !q_full;

        doc_delta = doc_id - prev_doc_reg;
        off_delta = position_word[OFFSET_W-1:0] - prev_off_reg;
        word0     = {doc_delta[WORD_W-2:0], 1'b0} ^ {WORD_W{doc_delta[WORD_W-1]}};
        word1     = {position_word[WORD_W-1:OFFSET_W],
                     {off_delta[OFFSET_W-2:0], 1'b0} ^ {OFFSET_W{off_delta[OFFSET_W-1]}}};

        index_inc = {1'b0, index_reg} + 1'b1;
        block_end = index_inc >= {1'b0, count_eff};

        // An empty block drops the word and leaves the state alone.
        q_write = accept && (count_eff != '0);

        q_data.words     = {payload_word, word1, word0};
        q_data.index     = index_reg;
        q_data.stride    = count_eff;
        q_data.block_end = block_end;

        prev_doc_next = prev_doc_reg;
        prev_off_next = prev_off_reg;
        index_next    = index_reg;
        if (q_write)
        begin
            if (block_end)
            begin
                prev_doc_next = '0;
                prev_off_next = '0;
                index_next    = '0;
            end
            else
            begin
                prev_doc_next = doc_id;
                prev_off_next = position_word[OFFSET_W-1:0];
                index_next    = index_inc[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_doc_reg <= '0;
            prev_off_reg <= '0;
            index_reg    <= '0;
        end
        else
        begin
            prev_doc_reg <= prev_doc_next;
            prev_off_reg <= prev_off_next;
            index_reg    <= index_next;
        end
    end

endmodule

@@ sv/dzbp_queue.sv @@
// Short record queue between the front end and the byte serializer.
module dzbp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  dzbp_pkg::rec_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output dzbp_pkg::rec_t  rd_data
);
    import dzbp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    rec_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;

    always_comb
    begin
        full     = fill_reg == CNT_W'(QUEUE_DEPTH);
        rd_valid = fill_reg != '0;
        rd_data  = mem_reg[rptr_reg];

        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (wr_en)
        begin
            wptr_next = (wptr_reg == LAST_SLOT) ? '0 : wptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rptr_next = (rptr_reg == LAST_SLOT) ? '0 : rptr_reg + 1'b1;
        end
        fill_next = fill_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

@@ sv/dzbp_back.sv @@
// Back end: serializes a record into 24 addressed bytes through an output register.
module dzbp_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  dzbp_pkg::rec_t               q_data,
    output logic                         q_read,
    input  logic                         pop,
    output logic                         empty,
    output logic [dzbp_pkg::ADDR_W-1:0]  byte_address,
    output logic [dzbp_pkg::BYTE_W-1:0]  byte_value,
    output logic                         last_of_record,
    output logic                         last_of_block
);
    import dzbp_pkg::*;

    localparam int SHIFT_W = NUM_WORDS * WORD_W;

    logic                busy_reg;
    logic [SHIFT_W-1:0]  shift_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [COUNT_W-1:0]  stride_reg;
    logic                blk_end_reg;
    logic [BCNT_W-1:0]   bcnt_reg;

    logic                out_valid_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_lrec_reg;
    logic                out_lblk_reg;

    logic                taken;
    logic                emit;
    logic                finish;

    always_comb
    begin
        taken  = pop && out_valid_reg;
        emit   = busy_reg && (!out_valid_reg || taken);
        finish = emit && (bcnt_reg == LAST_BYTE);
        // The next record is loaded in the cycle the current one sends its last byte.
        q_read = q_valid && (!busy_reg || finish);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_read)
            begin
                busy_reg <= 1'b1;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_read)
        begin
            shift_reg   <= q_data.words;
            addr_reg    <= {{(ADDR_W-COUNT_W){1'b0}}, q_data.index};
            stride_reg  <= q_data.stride;
            blk_end_reg <= q_data.block_end;
            bcnt_reg    <= '0;
        end
        else if (emit)
        begin
            shift_reg <= {{BYTE_W{1'b0}}, shift_reg[SHIFT_W-1:BYTE_W]};
            // Plane stride added once per byte, wrapping at the address width.
            addr_reg  <= addr_reg + {{(ADDR_W-COUNT_W){1'b0}}, stride_reg};
            bcnt_reg  <= bcnt_reg + 1'b1;
        end

        if (emit)
        begin
            out_addr_reg <= addr_reg;
            out_byte_reg <= shift_reg[BYTE_W-1:0];
            out_lrec_reg <= bcnt_reg == LAST_BYTE;
            out_lblk_reg <= (bcnt_reg == LAST_BYTE) && blk_end_reg;
        end
    end

    assign empty          = !out_valid_reg;
    assign byte_address   = out_addr_reg;
    assign byte_value     = out_byte_reg;
    assign last_of_record = out_lrec_reg;
    assign last_of_block  = out_lblk_reg;

endmodule

@@ sv/delta_zigzag_byte_plane_encoder.sv @@
// Top level of the delta/zigzag byte-plane encoder.
// Each record pushed in (document id, position word, payload) comes out as 24 bytes, one
// per cycle while pop stays high, words in order and bytes little-endian, each tagged with
// its byte-plane address (8*word+byte)*record_count+index modulo 2^29. The rate is set by
// the single-byte result port fed from the serializer's shift register. The front end
// codes a record in the cycle it is pushed and hands it to a two-entry queue, so the next
// records are taken while earlier ones are still being sent; a record's first byte passes
// through the queue, the shift register and the output register. The user must write the
// record count register through the cfg port only while idle; the block does not enforce it.
// A count of zero drops pushed records, and counts above MAX_RECORDS are clamped.
module delta_zigzag_byte_plane_encoder #(
    parameter int MAX_RECORDS = 16777216
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dzbp_pkg::COUNT_W-1:0] cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [dzbp_pkg::WORD_W-1:0]  doc_id,
    input  logic [dzbp_pkg::WORD_W-1:0]  position_word,
    input  logic [dzbp_pkg::WORD_W-1:0]  payload_word,
    input  logic                         pop,
    output logic                         empty,
    output logic [dzbp_pkg::ADDR_W-1:0]  byte_address,
    output logic [dzbp_pkg::BYTE_W-1:0]  byte_value,
    output logic                         last_of_record,
    output logic                         last_of_block
);
    import dzbp_pkg::*;

    logic  q_write;
    rec_t  q_wdata;
    logic  q_read;
    logic  q_valid;
    rec_t  q_rdata;

    dzbp_front #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .push          (push),
        .q_full        (full),
        .doc_id        (doc_id),
        .position_word (position_word),
        .payload_word  (payload_word),
        .q_write       (q_write),
        .q_data        (q_wdata)
    );

    dzbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_write),
        .wr_data  (q_wdata),
        .full     (full),
        .rd_en    (q_read),
        .rd_valid (q_valid),
        .rd_data  (q_rdata)
    );

    dzbp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_data         (q_rdata),
        .q_read         (q_read),
        .pop            (pop),
        .empty          (empty),
        .byte_address   (byte_address),
        .byte_value     (byte_value),
        .last_of_record (last_of_record),
        .last_of_block  (last_of_block)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the delta/zigzag byte-plane encoder.
module tb_top;

    localparam int MAX_REC     = 16777216;
    localparam int DRAIN_CYCLS = 12;

    typedef struct {
        logic [dzbp_pkg::WORD_W-1:0] doc;
        logic [dzbp_pkg::WORD_W-1:0] pos;
        logic [dzbp_pkg::WORD_W-1:0] pay;
        bit                          hold;
    } pending_rec_t;

    typedef struct {
        logic [dzbp_pkg::ADDR_W-1:0] addr;
        logic [dzbp_pkg::BYTE_W-1:0] value;
        logic                        last_rec;
        logic                        last_blk;
    } plane_byte_t;

    logic                          clk            = 1'b0;
    logic                          rst_n          = 1'b0;
    logic                          cfg_valid      = 1'b0;
    logic                          cfg_ready;
    logic [dzbp_pkg::COUNT_W-1:0]  cfg_data       = '0;
    logic                          push           = 1'b0;
    logic                          full;
    logic [dzbp_pkg::WORD_W-1:0]   doc_id         = '0;
    logic [dzbp_pkg::WORD_W-1:0]   position_word  = '0;
    logic [dzbp_pkg::WORD_W-1:0]   payload_word   = '0;
    logic                          pop            = 1'b0;
    logic                          empty;
    logic [dzbp_pkg::ADDR_W-1:0]   byte_address;
    logic [dzbp_pkg::BYTE_W-1:0]   byte_value;
    logic                          last_of_record;
    logic                          last_of_block;

    // Predictor state.
    logic [dzbp_pkg::COUNT_W-1:0]  count_reg = '0;
    logic [dzbp_pkg::WORD_W-1:0]   last_doc  = '0;
    logic [dzbp_pkg::OFFSET_W-1:0] last_off  = '0;
    logic [23:0]                   rec_index = '0;

    pending_rec_t pending_records[$];
    plane_byte_t  expected_bytes[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatches    = 0;
    bit          send_now;

    // Stimulus generator state for mostly slowly rising sequences with occasional falls and jumps.
    logic [dzbp_pkg::WORD_W-1:0]   gen_doc = '0;
    logic [dzbp_pkg::OFFSET_W-1:0] gen_off = '0;

    delta_zigzag_byte_plane_encoder #(
        .MAX_RECORDS(MAX_REC)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .doc_id        (doc_id),
        .position_word (position_word),
        .payload_word  (payload_word),
        .pop           (pop),
        .empty         (empty),
        .byte_address  (byte_address),
        .byte_value    (byte_value),
        .last_of_record(last_of_record),
        .last_of_block (last_of_block)
    );

    always #4 clk = ~clk;

    task automatic report_error(input string msg);
        $display("tb_top: mismatch: %s", msg);
        mismatches++;
    endtask

    // Works out the 24 plane bytes of one accepted record and advances the state; none at a zero count.
    task automatic encode_record(input pending_rec_t r);
        logic [dzbp_pkg::COUNT_W-1:0]  eff;
        logic [dzbp_pkg::WORD_W-1:0]   doc_delta;
        logic [dzbp_pkg::OFFSET_W-1:0] off_delta;
        logic [dzbp_pkg::WORD_W-1:0]   words [3];
        logic                          blk_end;
        longint unsigned               addr;
        plane_byte_t                   pb;
        eff = (count_reg > dzbp_pkg::COUNT_W'(MAX_REC)) ? dzbp_pkg::COUNT_W'(MAX_REC)
                                                       : count_reg;
        if (eff == '0)
            return;
        doc_delta = r.doc - last_doc;
        off_delta = r.pos[dzbp_pkg::OFFSET_W-1:0] - last_off;
        words[0]  = {doc_delta[62:0], 1'b0} ^ {64{doc_delta[63]}};
        words[1]  = {r.pos[63:48], {off_delta[46:0], 1'b0} ^ {48{off_delta[47]}}};
        words[2]  = r.pay;
        blk_end   = (({1'b0, rec_index} + 25'd1) >= eff);
        for (int k = 0; k < 24; k++)
        begin
            addr        = 64'(k) * 64'(eff) + 64'(rec_index);
            pb.addr     = addr[dzbp_pkg::ADDR_W-1:0];
            pb.value    = words[k / 8][8 * (k % 8) +: 8];
            pb.last_rec = (k == 23);
            pb.last_blk = (k == 23) && blk_end;
            expected_bytes.push_back(pb);
        end
        if (blk_end)
        begin
            last_doc  = '0;
            last_off  = '0;
            rec_index = '0;
        end
        else
        begin
            last_doc  = r.doc;
            last_off  = r.pos[dzbp_pkg::OFFSET_W-1:0];
            rec_index = rec_index + 24'd1;
        end
    endtask

    // Driver: a word is taken at an edge with push high and full low.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && full)
            begin
                send_now = 1'b1;
            end
            else
            begin
                if (push)
                begin
                    encode_record(pending_records[0]);
                    void'(pending_records.pop_front());
                end
                send_now = (pending_records.size() != 0)
                           && !(pending_records.size() != 0 && pending_records[0].hold
                                && expected_bytes.size() != 0)
                           && ($urandom_range(0, 99) >= send_idle_pct);
            end
            push <= send_now;
            if (send_now)
            begin
                doc_id        <= pending_records[0].doc;
                position_word <= pending_records[0].pos;
                payload_word  <= pending_records[0].pay;
            end
        end
    end

    // Monitor: the oldest byte is taken at an edge with pop high and empty low.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_error($sformatf("unexpected word addr %0h value %0h",
                                           byte_address, byte_value));
                end
                else
                begin
                    if (byte_address !== expected_bytes[0].addr)
                        report_error($sformatf("byte_address got %0h want %0h",
                                               byte_address, expected_bytes[0].addr));
                    if (byte_value !== expected_bytes[0].value)
                        report_error($sformatf("byte_value got %0h want %0h",
                                               byte_value, expected_bytes[0].value));
                    if (last_of_record !== expected_bytes[0].last_rec)
                        report_error($sformatf("last_of_record got %0b want %0b",
                                               last_of_record, expected_bytes[0].last_rec));
                    if (last_of_block !== expected_bytes[0].last_blk)
                        report_error($sformatf("last_of_block got %0b want %0b",
                                               last_of_block, expected_bytes[0].last_blk));
                    void'(expected_bytes.pop_front());
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic add_record(input logic [63:0] doc, input logic [63:0] pos,
                              input logic [63:0] pay, input bit hold);
        pending_rec_t r;
        r.doc  = doc;
        r.pos  = pos;
        r.pay  = pay;
        r.hold = hold;
        pending_records.push_back(r);
    endtask

    // Dropped records leave no trace, so the task also waits out the DRAIN_CYCLS drain before the block counts as idle.
    task automatic wait_idle();
        while (pending_records.size() != 0 || expected_bytes.size() != 0 || push)
            @(posedge clk);
        repeat (DRAIN_CYCLS) @(posedge clk);
    endtask

    task automatic write_count(input logic [dzbp_pkg::COUNT_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_reg  = value;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [dzbp_pkg::COUNT_W-1:0] pick_count();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return 25'd1;
        else if (sel <= 13)
            return 25'($urandom_range(2, 8));
        else if (sel <= 15)
            return 25'(MAX_REC);
        else if (sel == 16)
            return '1;
        else if (sel == 17)
            return 25'($urandom());
        return 25'($urandom_range(9, 40));
    endfunction

    task automatic add_random_record();
        logic [63:0] doc;
        logic [47:0] off;
        logic [63:0] pos;
        int unsigned mode;
        mode = $urandom_range(0, 9);
        pos  = rand64();
        if (mode <= 5)
        begin
            doc = gen_doc + 64'($urandom_range(0, 300));
            off = gen_off + 48'($urandom_range(0, 5000));
        end
        else if (mode == 6)
        begin
            doc = gen_doc - 64'($urandom_range(1, 300));
            off = gen_off - 48'($urandom_range(1, 5000));
        end
        else if (mode == 7)
        begin
            doc = rand64();
            off = pos[47:0];
        end
        else if (mode == 8)
        begin
            doc = ($urandom_range(0, 1) != 0) ? 64'h8000_0000_0000_0000 : '1;
            off = ($urandom_range(0, 1) != 0) ? 48'h8000_0000_0000 : '0;
        end
        else
        begin
            doc = rand64();
            off = 48'hFFFF_FFFF_F000 + 48'($urandom_range(0, 8191));
        end
        gen_doc = doc;
        gen_off = off;
        add_record(doc, {pos[63:48], off}, rand64(), $urandom_range(0, 29) == 0);
    endtask

    initial
    begin
        int unsigned phase_items;
        int unsigned seg_len;
        logic [dzbp_pkg::COUNT_W-1:0] cnt;

        send_idle_pct = 26;
        recv_idle_pct = 63;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // The count resets to zero, so these records are dropped.
        add_record(rand64(), rand64(), rand64(), 1'b0);
        add_record('1, '1, '1, 1'b0);

        write_count(25'd3);
        add_record('0, '0, '0, 1'b0);
        add_record('1, '1, '1, 1'b0);
        add_record(64'h8000_0000_0000_0000, 64'h0000_8000_0000_0000,
                   64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
        add_record(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_7FFF_FFFF_FFFF,
                   64'hA5A5_A5A5_A5A5_A5A5, 1'b1);
        add_record(64'h7FFF_FFFF_FFFF_FFFA, 64'h1234_7FFF_FFFF_FF00, rand64(), 1'b0);
        add_record(64'h8000_0000_0000_0010, 64'h0001_8000_0000_0100, rand64(), 1'b0);

        write_count(25'd1);
        add_record(rand64(), rand64(), rand64(), 1'b0);
        add_record(rand64(), rand64(), rand64(), 1'b0);

        // Oversized counts are clamped to the largest block.
        write_count('1);
        add_record(rand64(), rand64(), '0, 1'b0);
        add_record(rand64(), rand64(), '1, 1'b0);
        write_count(25'(MAX_REC + 1));
        add_record(rand64(), rand64(), rand64(), 1'b0);
        write_count(25'(MAX_REC));
        add_record(rand64(), rand64(), rand64(), 1'b0);

        // Lowering the count below the running index closes the block at once.
        write_count(25'd5);
        add_record(64'd100, 64'd1000, rand64(), 1'b0);
        add_record(64'd90, 64'd900, rand64(), 1'b0);
        add_record(64'd95, 64'd950, rand64(), 1'b0);
        write_count(25'd2);
        add_record(64'd99, 64'd990, rand64(), 1'b0);
        add_record(64'd7, 64'd70, rand64(), 1'b0);

        // Raising the count or parking at zero mid-block keeps index and history.
        write_count(25'd9);
        add_record(64'd20, 64'd200, rand64(), 1'b0);
        write_count('0);
        add_record(64'd30, 64'd300, rand64(), 1'b0);
        write_count(25'd9);
        add_record(64'd25, 64'd250, rand64(), 1'b0);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 63 : 0;
            recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 26 : 0;
            phase_items   = 0;
            while (phase_items < 27)
            begin
                cnt     = pick_count();
                write_count(cnt);
                seg_len = $urandom_range(6, 12);
                repeat (seg_len) add_random_record();
                if (cnt != '0)
                    phase_items += seg_len;
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
